// File: sv/bch_pkg.sv
// Shared types, constants and syndrome table for the BCH(31,21) corrector.
`timescale 1ns / 1ps
package bch_pkg;

   localparam int BlockBits = 31;
   localparam int CheckBits = 10;
   localparam int WordBits  = 32;
   localparam int FixBits   = 2;
   localparam int RspBits   = 40;
   localparam logic [CheckBits:0] BchGen = 11'h769;

   typedef logic [CheckBits-1:0] syn_type;
   typedef syn_type [BlockBits-1:0] syn_table_type;

   // Error locator status passed to the top level.
   typedef struct packed {
      logic [BlockBits-1:0] err;
      logic                 hit_single;
      logic                 hit_double;
   } loc_type;

   localparam logic [FixBits-1:0] FixNone = 2'd0;
   localparam logic [FixBits-1:0] FixOne  = 2'd1;
   localparam logic [FixBits-1:0] FixTwo  = 2'd2;

   // Syndrome of each single-bit pattern, built at elaboration.
   function automatic syn_table_type build_single_syn();
      syn_table_type        t;
      logic [BlockBits-1:0] v;
      for (int i = 0; i < BlockBits; i++) begin
         v = BlockBits'(1) << i;
         for (int k = BlockBits - 1; k >= CheckBits; k--) begin
            if (v[k]) begin
               v = v ^ (BlockBits'(BchGen) << (k - CheckBits));
            end
         end
         t[i] = v[CheckBits-1:0];
      end
      return t;
   endfunction

   localparam syn_table_type SingleSyn = build_single_syn();

endpackage

// File: sv/bch_syndrome.sv
// Syndrome of the 31-bit block as the XOR of per-bit syndromes.
`timescale 1ns / 1ps
module bch_syndrome (
   input  logic [bch_pkg::BlockBits-1:0] blk,
   output bch_pkg::syn_type              syn
);

   always_comb begin
      syn = '0;
      for (int i = 0; i < bch_pkg::BlockBits; i++) begin
         if (blk[i]) begin
            syn = syn ^ bch_pkg::SingleSyn[i];
         end
      end
   end

endmodule

// File: sv/bch_locator.sv
// Error locator: matches a syndrome against all weight-1 and weight-2 patterns.
`timescale 1ns / 1ps
module bch_locator (
   input  bch_pkg::syn_type syn,
   output bch_pkg::loc_type loc
);

   logic [bch_pkg::BlockBits-1:0] single_hit;
   logic [bch_pkg::BlockBits-1:0] pair_flip;
   logic                          pair_any;

   // Code distance is 5, so at most one pattern of weight <= 2 matches.
   always_comb begin
      pair_flip = '0;
      pair_any  = 1'b0;
      for (int i = 0; i < bch_pkg::BlockBits; i++) begin
         single_hit[i] = (syn == bch_pkg::SingleSyn[i]);
         for (int j = i + 1; j < bch_pkg::BlockBits; j++) begin
            if ((bch_pkg::SingleSyn[i] ^ bch_pkg::SingleSyn[j]) == syn) begin
               pair_flip[i] = 1'b1;
               pair_flip[j] = 1'b1;
               pair_any     = 1'b1;
            end
         end
      end
      loc.hit_single = |single_hit;
      loc.hit_double = pair_any & ~loc.hit_single;
      loc.err        = loc.hit_single ? single_hit : pair_flip;
   end

endmodule

// File: sv/bch_31_21_double_error_corrector.sv
// Top level: registered BCH(31,21) double-error corrector for paging codewords.
// An accepted req beat goes into the input register, its result into the result register.
// Throughput: one codeword per cycle while rsp_tready stays high; all decode logic sits between the
// input register and the result register, bounded by the pair-syndrome compare.
// Reset: synchronous, active high; clears both stage valid flags, payload kept.
`timescale 1ns / 1ps
module bch_31_21_double_error_corrector (
   input  logic                        clock,
   input  logic                        reset,
   // req channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bch_pkg::WordBits-1:0] req_tdata,  // [31:0] received_word
   // rsp channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bch_pkg::RspBits-1:0] rsp_tdata,   // [31:0] corrected_word,
                                                    // [33:32] bits_fixed, rest 0
   output logic                        rsp_tuser    // [0] valid_res
);

   // Stage 1: input register
   logic                         in_v_ff;
   logic [bch_pkg::WordBits-1:0] word_ff;

   // Stage 2: result register
   logic                         out_v_ff;
   logic [bch_pkg::WordBits-1:0] res_word_ff, res_word_in;
   logic [bch_pkg::FixBits-1:0]  res_fix_ff, res_fix_in;
   logic                         res_ok_ff, res_ok_in;

   logic             adv_out;
   logic             adv_in;
   bch_pkg::syn_type syn;
   bch_pkg::loc_type loc;
   logic             par_odd;
   logic [bch_pkg::WordBits-1:0] flipped;

   // A result leaves when taken or when the slot is empty; the input stage
   // moves up whenever the result slot frees, so beats flow every cycle while rsp_tready is high.
   assign adv_out    = ~out_v_ff | rsp_tready;
   assign req_tready = ~in_v_ff | adv_out;
   assign adv_in     = req_tvalid & req_tready;

   bch_syndrome u_syn (
      .blk (word_ff[bch_pkg::WordBits-1:1]),
      .syn (syn)
   );

   bch_locator u_loc (
      .syn (syn),
      .loc (loc)
   );

   assign par_odd = ^word_ff;
   assign flipped = word_ff ^ {loc.err, 1'b0};

   // Decode: clean block fixes parity only; a single block error may also
   // take a parity fix; a double with odd parity left means a third error.
   always_comb begin
      res_ok_in   = 1'b0;
      res_word_in = '0;
      res_fix_in  = bch_pkg::FixNone;
      if (syn == '0) begin
         res_ok_in   = 1'b1;
         res_word_in = {word_ff[bch_pkg::WordBits-1:1], word_ff[0] ^ par_odd};
         res_fix_in  = par_odd ? bch_pkg::FixOne : bch_pkg::FixNone;
      end else if (loc.hit_single) begin
         // one flip toggles parity: odd afterwards iff word parity was even
         res_ok_in   = 1'b1;
         res_word_in = {flipped[bch_pkg::WordBits-1:1], flipped[0] ^ ~par_odd};
         res_fix_in  = par_odd ? bch_pkg::FixOne : bch_pkg::FixTwo;
      end else if (loc.hit_double && !par_odd) begin
         res_ok_in   = 1'b1;
         res_word_in = flipped;
         res_fix_in  = bch_pkg::FixTwo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_v_ff <= req_tvalid;
         end
         if (adv_out) begin
            out_v_ff <= in_v_ff;
         end
      end
      if (adv_in) begin
         word_ff <= req_tdata;
      end
      if (adv_out && in_v_ff) begin
         res_word_ff <= res_word_in;
         res_fix_ff  <= res_fix_in;
         res_ok_ff   <= res_ok_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = res_ok_ff;
   assign rsp_tdata  = {{(bch_pkg::RspBits - bch_pkg::WordBits - bch_pkg::FixBits){1'b0}},
                        res_fix_ff, res_word_ff};

endmodule

// File: verif/tb_bch_31_21_double_error_corrector.sv
// Self-checking testbench for the BCH(31,21) double-error corrector.
`timescale 1ns / 1ps
module tb_bch_31_21_double_error_corrector;

   // Decoded outcome of one received word.
   typedef struct packed {
      logic                         ok;      // valid_res
      logic [bch_pkg::WordBits-1:0] word;    // corrected_word
      logic [bch_pkg::FixBits-1:0]  fixed;   // bits_fixed
   } fix_result_type;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [bch_pkg::WordBits-1:0] req_tdata  = '0;  // [31:0] received_word
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [bch_pkg::RspBits-1:0]  rsp_tdata;  // [31:0] corrected_word, [33:32] bits_fixed
   logic                         rsp_tuser;  // [0] valid_res

   bch_31_21_double_error_corrector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // syndrome of each single block bit
   logic [bch_pkg::CheckBits-1:0] bit_syn [0:bch_pkg::BlockBits-1];
   logic [bch_pkg::WordBits-1:0]  codeword_q [$];  // words still to be sent
   fix_result_type                decoded_q [$];   // outcomes awaiting their rsp beat
   int                            words_total  = 0;
   int                            words_sent   = 0;
   int                            results_seen = 0;
   int                            fail_count   = 0;
   int                            req_gap      = 0;
   int                            rsp_stall    = 0;
   bit                            req_free;
   bit                            rsp_hold     = 1'b0;
   fix_result_type                want;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Remainder of a 31-bit block divided by the generator.
   function automatic logic [bch_pkg::CheckBits-1:0] block_syndrome(
         input logic [bch_pkg::BlockBits-1:0] blk);
      logic [bch_pkg::BlockBits-1:0] v;
      v = blk;
      for (int k = bch_pkg::BlockBits - 1; k >= bch_pkg::CheckBits; k--) begin
         if (v[k]) begin
            v = v ^ ({20'b0, bch_pkg::BchGen} << (k - bch_pkg::CheckBits));
         end
      end
      return v[bch_pkg::CheckBits-1:0];
   endfunction

   // Clean word: 21 message bits, 10 check bits, even parity in bit 0.
   function automatic logic [bch_pkg::WordBits-1:0] make_codeword(input logic [20:0] msg);
      logic [bch_pkg::BlockBits-1:0] blk;
      blk = {msg, 10'b0};
      blk[bch_pkg::CheckBits-1:0] = block_syndrome(blk);
      return {blk, ^blk};
   endfunction

   // Appends one word to the send queue.
   function automatic void enqueue_word(input logic [bch_pkg::WordBits-1:0] w);
      codeword_q.insert(codeword_q.size(), w);
   endfunction

   // Expected decode: single patterns searched first, then pairs in index order.
   function automatic fix_result_type decode_word(input logic [bch_pkg::WordBits-1:0] r);
      fix_result_type                res;
      logic [bch_pkg::CheckBits-1:0] syn;
      logic [bch_pkg::BlockBits-1:0] err;
      logic [bch_pkg::WordBits-1:0]  w;
      int                            cnt;
      res = '0;
      err = '0;
      cnt = 0;
      syn = block_syndrome(r[bch_pkg::WordBits-1:1]);
      if (syn == '0) begin
         res.ok    = 1'b1;
         res.word  = r ^ {31'b0, ^r};
         res.fixed = (^r) ? bch_pkg::FixOne : bch_pkg::FixNone;
         return res;
      end
      for (int i = 0; i < bch_pkg::BlockBits; i++) begin
         if (cnt == 0 && bit_syn[i] == syn) begin
            err[i] = 1'b1;
            cnt    = 1;
         end
      end
      for (int i = 0; i < bch_pkg::BlockBits; i++) begin
         for (int j = i + 1; j < bch_pkg::BlockBits; j++) begin
            if (cnt == 0 && (bit_syn[i] ^ bit_syn[j]) == syn) begin
               err[i] = 1'b1;
               err[j] = 1'b1;
               cnt    = 2;
            end
         end
      end
      if (cnt == 0) begin
         return res;
      end
      w = r ^ {err, 1'b0};
      if (^w) begin
         // odd parity after a pair fix means a third error
         if (cnt == 2) begin
            return res;
         end
         w[0] = ~w[0];
         cnt++;
      end
      res.ok    = 1'b1;
      res.word  = w;
      res.fixed = cnt[bch_pkg::FixBits-1:0];
      return res;
   endfunction

   // Codeword with up to three distinct block errors and a random parity flip.
   function automatic logic [bch_pkg::WordBits-1:0] noisy_codeword();
      logic [bch_pkg::WordBits-1:0] mask;
      int                           nerr;
      int                           r;
      mask = '0;
      r    = $urandom_range(99, 0);
      nerr = (r < 20) ? 0 : (r < 50) ? 1 : (r < 85) ? 2 : 3;
      while ($countones(mask) < nerr) begin
         mask[$urandom_range(31, 1)] = 1'b1;
      end
      mask[0] = 1'($urandom_range(1, 0));
      return make_codeword(21'($urandom)) ^ mask;
   endfunction

   // Idle length after a beat: mostly short, a few long, with idle-free windows.
   function automatic int pick_gap(input int n);
      int r;
      if ((n / 96) % 4 == 2) begin
         return 0;
      end
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Driver: offers queued words; the expected outcome is logged on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         req_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            decoded_q.insert(decoded_q.size(), decode_word(req_tdata));
            words_sent++;
            req_free = 1'b1;
            req_gap  = pick_gap(words_sent);
         end
         if (req_free) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (codeword_q.size() != 0) begin
               req_tdata  <= codeword_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each rsp beat against the oldest outcome, then paces ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            rsp_stall = pick_gap(results_seen);
            if (decoded_q.size() == 0) begin
               $error("unexpected rsp beat: corrected_word %h", rsp_tdata[31:0]);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tuser !== want.ok) begin
                  $error("valid_res: expected %0d, actual %0d", want.ok, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[31:0] !== want.word) begin
                  $error("corrected_word: expected %h, actual %h", want.word, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[33:32] !== want.fixed) begin
                  $error("bits_fixed: expected %0d, actual %0d", want.fixed, rsp_tdata[33:32]);
                  fail_count++;
               end
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Back-pressure: one long receiver hold-off mid-run so the block fills up.
   initial begin
      wait (results_seen >= 300);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      logic [bch_pkg::WordBits-1:0] cw;
      for (int i = 0; i < bch_pkg::BlockBits; i++) begin
         bit_syn[i] = block_syndrome(bch_pkg::BlockBits'(1) << i);
      end

      // directed: extremes, clean words, parity-only, single, pair, pair plus parity, triple
      cw = make_codeword(21'h1FFFFF);
      enqueue_word(32'h0000_0000);
      enqueue_word(32'h0000_0001);
      enqueue_word(32'hFFFF_FFFF);
      enqueue_word(32'h8000_0000);
      enqueue_word(32'h7FFF_FFFF);
      enqueue_word(32'hAAAA_AAAA);
      enqueue_word(32'h5555_5555);
      enqueue_word(cw);
      enqueue_word(cw ^ 32'h0000_0001);
      enqueue_word(cw ^ 32'h0000_0002);
      enqueue_word(cw ^ 32'h8000_0000);
      enqueue_word(cw ^ 32'h8000_0001);
      enqueue_word(cw ^ 32'h8000_0002);
      enqueue_word(cw ^ 32'h8000_0003);
      enqueue_word(cw ^ 32'h0001_0100);
      enqueue_word(cw ^ 32'h8000_4002);
      enqueue_word(cw ^ 32'h0000_000E);
      cw = make_codeword(21'h155555);
      enqueue_word(cw);
      enqueue_word(cw ^ 32'h0000_0400);
      enqueue_word(cw ^ 32'h0000_0C01);
      enqueue_word(cw ^ 32'h0700_0000);
      enqueue_word(make_codeword(21'h100000) ^ 32'h3000_0001);

      // random: mostly corrupted codewords, some raw noise
      for (int n = 0; n < 1150; n++) begin
         if ($urandom_range(99, 0) < 80) begin
            enqueue_word(noisy_codeword());
         end else begin
            enqueue_word($urandom);
         end
      end
      words_total = codeword_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (words_sent == words_total && results_seen >= words_sent);
      repeat (20) @(posedge clock);
      if (decoded_q.size() != 0) begin
         $error("%0d expected rsp beats never arrived", decoded_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
sv/bch_pkg.sv
sv/bch_syndrome.sv
sv/bch_locator.sv
sv/bch_31_21_double_error_corrector.sv
verif/tb_bch_31_21_double_error_corrector.sv
